// File: src/set_assoc_lru_cache_directory_defines.svh
// Assertion macros for the cache directory
`ifndef SET_ASSOC_LRU_CACHE_DIRECTORY_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_DIRECTORY_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define SALC_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication
`define SALC_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// File: src/salc_pkg.sv
// Shared constants and types of the cache directory
package salc_pkg;
    localparam int TOTAL_LINES = 512;
    localparam int LINE_BYTES  = 32;
    localparam int MAX_WAYS    = 16;
    localparam int ADDR_BITS   = 32;
    localparam int SLOT_W      = $clog2(TOTAL_LINES);
    localparam int OFF_W       = $clog2(LINE_BYTES);
    localparam int BLOCK_W     = ADDR_BITS - OFF_W;
    localparam int WAY_W       = $clog2(MAX_WAYS);
    localparam int WL_W        = 3;
    localparam int STAMP_W     = 48;
    localparam int CNT_W       = 32;
    localparam int MAX_WL      = (MAX_WAYS < TOTAL_LINES) ? $clog2(MAX_WAYS)
                                                          : $clog2(TOTAL_LINES);

    localparam logic [1:0] CFG_WAYS     = 2'd0;
    localparam logic [1:0] CFG_ALLOC    = 2'd1;
    localparam logic [1:0] CFG_PREFETCH = 2'd2;

    localparam logic [1:0] PF_NONE   = 2'd0;
    localparam logic [1:0] PF_ALWAYS = 2'd1;
    localparam logic [1:0] PF_MISS   = 2'd2;

    typedef struct packed {
        logic load;      // latch request
        logic start;     // begin lookup of current block
        logic sel_next;  // look up next block
        logic step;      // scan one way
        logic commit;    // touch or fill
        logic do_fill;
        logic count;     // update counters
        logic set_pf;    // record prefetch fill
    } salc_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic store;
        logic clearing;  // valid bits being cleared after reset
    } salc_sts_t;
endpackage

// File: src/salc_ctrl.sv
// Sequencing controller for lookup, fill and prefetch
module salc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                alloc_store,
    input  logic [1:0]          pf_mode,
    input  salc_pkg::salc_sts_t sts,
    output salc_pkg::salc_cmd_t cmd
);
    import salc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DSCAN = 3'd1;
    localparam logic [2:0] S_DCOMMIT = 3'd2;
    localparam logic [2:0] S_PSTART = 3'd3;
    localparam logic [2:0] S_PSCAN = 3'd4;
    localparam logic [2:0] S_PCOMMIT = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       hit_reg, hit_next;
    logic       do_pf;

    assign in_stall  = (state_reg != S_IDLE) || sts.clearing;
    assign out_valid = (state_reg == S_OUT);
    assign do_pf = (pf_mode == PF_ALWAYS) || ((pf_mode == PF_MISS) && !hit_reg);

    always_comb
    begin
        state_next = state_reg;
        hit_next   = hit_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !sts.clearing)
                begin
                    cmd.load  = 1'b1;
                    cmd.start = 1'b1;
                    state_next = S_DSCAN;
                end
            end
            S_DSCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_done)
                    state_next = S_DCOMMIT;
            end
            S_DCOMMIT:
            begin
                hit_next   = sts.found;
                cmd.count  = 1'b1;
                cmd.commit = sts.found || !sts.store || alloc_store;
                cmd.do_fill = !sts.found;
                state_next = S_PSTART;
            end
            S_PSTART:
            begin
                if (do_pf)
                begin
                    cmd.start    = 1'b1;
                    cmd.sel_next = 1'b1;
                    state_next   = S_PSCAN;
                end
                else
                    state_next = S_OUT;
            end
            S_PSCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_done)
                    state_next = S_PCOMMIT;
            end
            S_PCOMMIT:
            begin
                cmd.commit  = 1'b1;
                cmd.do_fill = !sts.found;
                cmd.set_pf  = !sts.found;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
        end
    end
endmodule

// File: src/salc_datapath.sv
// Tag, valid and stamp storage with way scan, victim pick and counters
module salc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  salc_pkg::salc_cmd_t  cmd,
    output salc_pkg::salc_sts_t  sts,
    input  logic [salc_pkg::WL_W-1:0] ways_log2,
    input  logic                 req_type,
    input  logic [31:0]          address,
    output logic                 hit,
    output logic                 prefetch_filled,
    output logic [31:0]          hit_count,
    output logic [31:0]          reference_count
);
    import salc_pkg::*;

    logic [BLOCK_W-1:0] tag_mem [TOTAL_LINES];
    logic [STAMP_W-1:0] stamp_mem [TOTAL_LINES];
    logic               valid_mem [TOTAL_LINES];

    logic [BLOCK_W-1:0] block_reg, look_reg;
    logic               store_reg;
    logic [WL_W-1:0]    wl_reg;
    logic [SLOT_W-1:0]  base_reg, base_next;
    logic [WAY_W:0]     way_reg;
    logic               busy_reg;
    logic               found_reg;
    logic [SLOT_W-1:0]  fslot_reg, vslot_reg;
    logic               vinv_reg, vhave_reg;
    logic [STAMP_W-1:0] best_reg;
    logic [BLOCK_W-1:0] rtag_reg;
    logic [STAMP_W-1:0] rstamp_reg;
    logic               rvalid_reg, rpend_reg;
    logic [SLOT_W-1:0]  rslot_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic [CNT_W-1:0]   hits_reg, refs_reg;
    logic               hit_reg, pf_reg;
    logic [SLOT_W-1:0]  clr_reg;
    logic               clr_busy_reg;
    logic [WL_W-1:0]    wl_eff;
    logic [WL_W-1:0]    wl_use;
    logic [BLOCK_W-1:0] look_next;
    logic [WAY_W:0]     ways_n;
    logic [SLOT_W-1:0]  rd_slot;
    logic [STAMP_W-1:0] tick_val;
    logic [SLOT_W-1:0]  set_mask;
    logic               rd_now;
    logic [SLOT_W-1:0]  wr_slot;

    assign wl_eff = (ways_log2 > WL_W'(MAX_WL)) ? WL_W'(MAX_WL) : ways_log2;
    assign wl_use = cmd.load ? wl_eff : wl_reg;
    assign ways_n = (WAY_W+1)'(1) << wl_reg;
    assign look_next = cmd.sel_next ? block_reg + BLOCK_W'(1)
                                    : BLOCK_W'(address >> OFF_W);
    assign set_mask = {SLOT_W{1'b1}} >> wl_use;
    // set base = (block mod sets) * ways
    assign base_next = (SLOT_W'(look_next) & set_mask) << wl_use;
    assign rd_now  = busy_reg && (way_reg < ways_n);
    assign rd_slot = base_reg + SLOT_W'(way_reg);
    assign tick_val = (clock_reg == {STAMP_W{1'b1}}) ? clock_reg
                                                     : clock_reg + STAMP_W'(1);
    assign wr_slot = cmd.do_fill ? vslot_reg : fslot_reg;

    assign sts.scan_done = !busy_reg && !rpend_reg;
    assign sts.found = found_reg;
    assign sts.store = store_reg;
    assign sts.clearing = clr_busy_reg;

    // memory read port and writes
    always_ff @(posedge clk)
    begin
        rtag_reg   <= tag_mem[rd_slot];
        rstamp_reg <= stamp_mem[rd_slot];
        rslot_reg  <= rd_slot;
        rvalid_reg <= valid_mem[rd_slot];
        if (clr_busy_reg)
            valid_mem[clr_reg] <= 1'b0;
        else if (cmd.commit && cmd.do_fill && vhave_reg)
            valid_mem[wr_slot] <= 1'b1;
        if (cmd.commit && (cmd.do_fill ? vhave_reg : 1'b1))
        begin
            stamp_mem[wr_slot] <= tick_val;
            if (cmd.do_fill)
                tag_mem[wr_slot] <= look_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_busy_reg <= 1'b1;
            busy_reg  <= 1'b0;
            rpend_reg <= 1'b0;
            clock_reg <= '0;
            hits_reg  <= '0;
            refs_reg  <= '0;
            wl_reg    <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
                if (clr_reg == {SLOT_W{1'b1}})
                    clr_busy_reg <= 1'b0;
            end
            rpend_reg <= cmd.step && rd_now;
            if (cmd.load)
                wl_reg <= wl_eff;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (cmd.step && busy_reg && !rd_now)
                busy_reg <= 1'b0;
            else if (cmd.step && rd_now && (way_reg + (WAY_W+1)'(1) >= ways_n))
                busy_reg <= 1'b0;
            if (cmd.commit && (cmd.do_fill ? vhave_reg : 1'b1))
                clock_reg <= tick_val;
            if (cmd.count)
            begin
                if (refs_reg != {CNT_W{1'b1}})
                    refs_reg <= refs_reg + CNT_W'(1);
                if (found_reg && hits_reg != {CNT_W{1'b1}})
                    hits_reg <= hits_reg + CNT_W'(1);
            end
        end
    end

    // scan state; payload regs
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            block_reg <= BLOCK_W'(address >> OFF_W);
            store_reg <= req_type;
            pf_reg    <= 1'b0;
        end
        if (cmd.count)
            hit_reg <= found_reg;
        if (cmd.set_pf)
            pf_reg <= 1'b1;
        if (cmd.start)
        begin
            look_reg   <= look_next;
            base_reg   <= base_next;
            way_reg    <= '0;
            found_reg  <= 1'b0;
            vinv_reg   <= 1'b0;
            vhave_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.step && rd_now)
                way_reg <= way_reg + (WAY_W+1)'(1);
            if (rpend_reg)
            begin
                if (rvalid_reg && rtag_reg == look_reg && !found_reg)
                begin
                    found_reg <= 1'b1;
                    fslot_reg <= rslot_reg;
                end
                if (!vinv_reg)
                begin
                    if (!rvalid_reg)
                    begin
                        vinv_reg  <= 1'b1;
                        vhave_reg <= 1'b1;
                        vslot_reg <= rslot_reg;
                    end
                    else if (!vhave_reg || rstamp_reg < best_reg)
                    begin
                        vhave_reg <= 1'b1;
                        vslot_reg <= rslot_reg;
                        best_reg  <= rstamp_reg;
                    end
                end
            end
        end
    end

    assign hit = hit_reg;
    assign prefetch_filled = pf_reg;
    assign hit_count = hits_reg;
    assign reference_count = refs_reg;
endmodule

// File: src/set_assoc_lru_cache_directory.sv
// Top level of the set-associative LRU cache directory
// Requests are handled one at a time: the input stalls from acceptance until the result is taken,
// and the ways of a set (ways = 1..16) are read serially, one way per scan step, from the
// tag, valid and stamp memory.
// Reset: asynchronous, active low; clears counters and the access clock and resets the
// configuration, then a pass over all 512 lines clears the valid bits while the input stalls.
`include "set_assoc_lru_cache_directory_defines.svh"
module set_assoc_lru_cache_directory (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        prefetch_filled,
    output logic [31:0] hit_count,
    output logic [31:0] reference_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import salc_pkg::*;

    logic [WL_W-1:0] ways_log2_reg;
    logic            alloc_reg;
    logic [1:0]      pf_mode_reg;
    salc_cmd_t       cmd;
    salc_sts_t       sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_log2_reg <= '0;
            alloc_reg     <= 1'b1;
            pf_mode_reg   <= PF_NONE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WAYS:     ways_log2_reg <= cfg_data[WL_W-1:0];
                CFG_ALLOC:    alloc_reg <= cfg_data[0];
                CFG_PREFETCH: pf_mode_reg <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    salc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .alloc_store(alloc_reg),
        .pf_mode(pf_mode_reg), .sts(sts), .cmd(cmd)
    );

    salc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .ways_log2(ways_log2_reg),
        .req_type(req_type), .address(address), .hit(hit),
        .prefetch_filled(prefetch_filled), .hit_count(hit_count),
        .reference_count(reference_count)
    );

    `SALC_ASSERT_IMP(a_hits_le_refs, clk, rst_n, out_valid, hit_count <= reference_count, "hits exceed references")
    `SALC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid, in_stall, "request accepted while result pending")
    `SALC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(hit_count), "stalled result changed")
endmodule

// File: tb/tb.sv
// Testbench for the set-associative LRU cache directory with next-line prefetch
`timescale 1ns / 1ps
module tb;
    import salc_pkg::*;

    typedef struct {
        logic        st;
        logic [31:0] addr;
    } req_t;

    typedef struct {
        logic        hit;
        logic        pf;
        logic [31:0] hc;
        logic [31:0] rc;
    } resp_t;

    localparam int unsigned NO_SLOT   = 32'hFFFF_FFFF;
    localparam int          IDLE_LIMIT = 20000;
    localparam int          LONG_HOLD  = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [31:0] address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        hit;
    logic        prefetch_filled;
    logic [31:0] hit_count;
    logic [31:0] reference_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    set_assoc_lru_cache_directory dut (.*);

    // directory model state
    logic [BLOCK_W-1:0] line_tag [TOTAL_LINES];
    logic               line_vld [TOTAL_LINES];
    logic [STAMP_W-1:0] line_use [TOTAL_LINES];
    logic [STAMP_W-1:0] use_clock;
    logic [CNT_W-1:0]   hits, refs;
    logic [2:0]         wl_reg;
    logic               alloc_reg;
    logic [1:0]         pf_reg;

    req_t  pend_req [$];
    resp_t due_resp [$];
    int    errs = 0;
    int    idle_cycles = 0;
    int    stall_pct = 0;
    int    hold_cnt = 0;
    int    gap_left = 0;
    int    burst_left = 1;
    int    gap_max = 4;
    logic  hold_tx = 1'b0;
    logic  long_req = 1'b0;
    logic  long_done = 1'b0;

    function automatic logic [STAMP_W-1:0] tick();
        if (use_clock != '1)
            use_clock = use_clock + 1;
        return use_clock;
    endfunction

    function automatic int unsigned set_start(logic [BLOCK_W-1:0] blk, int unsigned ways);
        int unsigned sets;
        sets = TOTAL_LINES / ways;
        return (blk % sets) * ways;
    endfunction

    function automatic int unsigned find_slot(logic [BLOCK_W-1:0] blk, int unsigned ways);
        int unsigned base;
        base = set_start(blk, ways);
        for (int unsigned w = 0; w < ways; w++)
            if (line_vld[base + w] && line_tag[base + w] == blk)
                return base + w;
        return NO_SLOT;
    endfunction

    function automatic void fill_slot(logic [BLOCK_W-1:0] blk, int unsigned ways);
        int unsigned base, victim;
        logic [STAMP_W-1:0] best;
        base = set_start(blk, ways);
        victim = NO_SLOT;
        best = '0;
        for (int unsigned w = 0; w < ways; w++) begin
            if (!line_vld[base + w]) begin
                victim = base + w;
                break;
            end
            if (victim == NO_SLOT || line_use[base + w] < best) begin
                victim = base + w;
                best = line_use[base + w];
            end
        end
        line_tag[victim] = blk;
        line_vld[victim] = 1'b1;
        line_use[victim] = tick();
    endfunction

    task automatic cache_access(input logic st, input logic [31:0] a);
        int unsigned ways, slot, ps;
        logic [BLOCK_W-1:0] blk, nb;
        logic h, pff, dopf;
        resp_t r;
        ways = 1 << ((wl_reg > MAX_WL) ? MAX_WL : wl_reg);
        blk = a[31:OFF_W];
        pff = 1'b0;
        if (refs != '1)
            refs = refs + 1;
        slot = find_slot(blk, ways);
        h = (slot != NO_SLOT);
        if (h) begin
            if (hits != '1)
                hits = hits + 1;
            line_use[slot] = tick();
        end else if (!st || alloc_reg) begin
            fill_slot(blk, ways);
        end
        dopf = (pf_reg == PF_ALWAYS) || (pf_reg == PF_MISS && !h);
        if (dopf) begin
            nb = blk + 1'b1;
            ps = find_slot(nb, ways);
            if (ps != NO_SLOT) begin
                line_use[ps] = tick();
            end else begin
                fill_slot(nb, ways);
                pff = 1'b1;
            end
        end
        r.hit = h;
        r.pf = pff;
        r.hc = hits;
        r.rc = refs;
        due_resp.push_back(r);
    endtask

    initial begin
        forever #6 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            logic showing;
            showing = in_valid;
            if (in_valid && !in_stall) begin
                cache_access(req_type, address);
                void'(pend_req.pop_front());
                showing = 1'b0;
            end
            if (!showing) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_req.size() > 0 && !hold_tx) begin
                    showing = 1'b1;
                    req_type <= pend_req[0].st;
                    address <= pend_req[0].addr;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end
            end
            in_valid <= showing;
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            resp_t e;
            if (out_valid && !out_stall) begin
                if (due_resp.size() == 0) begin
                    $display("%0t: unexpected result hit=%0b pf=%0b hc=%0d rc=%0d", $time,
                             hit, prefetch_filled, hit_count, reference_count);
                    errs++;
                end else begin
                    e = due_resp.pop_front();
                    if (hit !== e.hit) begin
                        $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
                        errs++;
                    end
                    if (prefetch_filled !== e.pf) begin
                        $display("%0t: prefetch_filled expected %0b actual %0b", $time,
                                 e.pf, prefetch_filled);
                        errs++;
                    end
                    if (hit_count !== e.hc) begin
                        $display("%0t: hit_count expected %0d actual %0d", $time,
                                 e.hc, hit_count);
                        errs++;
                    end
                    if (reference_count !== e.rc) begin
                        $display("%0t: reference_count expected %0d actual %0d", $time,
                                 e.rc, reference_count);
                        errs++;
                    end
                end
            end
            if (long_req && !long_done) begin
                long_done <= 1'b1;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WAYS)
            wl_reg = val[2:0];
        else if (idx == CFG_ALLOC)
            alloc_reg = val[0];
        else if (idx == CFG_PREFETCH)
            pf_reg = val[1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk);
        while (pend_req.size() > 0 || due_resp.size() > 0 || in_valid);
        repeat (80) @(posedge clk);
    endtask

    task automatic setup(input logic [2:0] wl, input logic al, input logic [1:0] pf);
        drain();
        write_reg(CFG_WAYS, {$urandom} & ~32'h7 | wl);
        write_reg(CFG_ALLOC, {$urandom} & ~32'h1 | al);
        write_reg(CFG_PREFETCH, {$urandom} & ~32'h3 | pf);
    endtask

    task automatic add(input logic st, input logic [31:0] a);
        req_t r;
        r.st = st;
        r.addr = a;
        pend_req.push_back(r);
    endtask

    task automatic random_burst(input int n);
        logic [31:0] base, a;
        int span;
        base = $urandom;
        span = $urandom_range(6, 11);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: a = $urandom;
                1: a = 32'hFFFF_FFFF - $urandom_range(0, 255);
                default: a = base + 32'($urandom_range(0, (1 << span) - 1) << OFF_W)
                             + $urandom_range(0, 31);
            endcase
            add(1'($urandom_range(0, 1)), a);
        end
    endtask

    initial begin
        logic [2:0] wl;
        logic [1:0] pf;
        for (int i = 0; i < TOTAL_LINES; i++) begin
            line_vld[i] = 1'b0;
            line_use[i] = '0;
            line_tag[i] = '0;
        end
        use_clock = '0;
        hits = '0;
        refs = '0;
        wl_reg = '0;
        alloc_reg = 1'b1;
        pf_reg = PF_NONE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: direct mapped, no prefetch
        add(1'b0, 32'h0000_0000);
        add(1'b0, 32'h0000_001F);
        add(1'b1, 32'h0000_4000);
        add(1'b0, 32'h0000_0000);
        add(1'b0, 32'hFFFF_FFFF);
        add(1'b1, 32'hFFFF_FFE0);
        add(1'b0, 32'hAAAA_AAAA);
        add(1'b1, 32'h5555_5555);

        // oversized way count, no store allocation, reserved prefetch mode
        setup(3'd7, 1'b0, 2'd3);
        add(1'b1, 32'h0001_0000);
        add(1'b1, 32'h0001_0000);
        add(1'b0, 32'h0001_0000);
        add(1'b1, 32'h0001_0000);
        add(1'b0, 32'h0000_0000);

        // prefetch always, last block wraps to zero
        setup(3'd4, 1'b1, PF_ALWAYS);
        add(1'b0, 32'hFFFF_FFFF);
        add(1'b0, 32'h0000_0010);
        add(1'b1, 32'h1234_5678);
        add(1'b0, 32'h1234_5698);

        // prefetch on miss, shrink the ways without flushing
        setup(3'd1, 1'b1, PF_MISS);
        add(1'b0, 32'h1234_5678);
        add(1'b0, 32'h0000_0000);
        add(1'b1, 32'h8000_0000);
        add(1'b0, 32'h8000_0020);

        for (int ph = 0; ph < 12; ph++) begin
            wl = (ph == 0) ? 3'd0 : (ph == 1) ? 3'd4 : 3'($urandom_range(0, 7));
            pf = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
            setup(wl, 1'($urandom_range(0, 1)), pf);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 12);
            if (ph == 5)
                long_req <= 1'b1;
            random_burst(95);
            if (ph == 7) begin
                hold_tx <= 1'b1;
                do @(posedge clk); while (due_resp.size() > 0 || in_valid);
                hold_tx <= 1'b0;
            end
        end

        drain();
        if (errs == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/salc_pkg.sv
src/salc_ctrl.sv
src/salc_datapath.sv
src/set_assoc_lru_cache_directory.sv
tb/tb.sv
